[rtl/ctel_pkg.sv]
// ----------------------------------------------------------------------------
// ctel_pkg
// Shared types and constants of the typed CSR edge lookup: table sizes,
// field widths, item codes and the beat formats of all channels.
// ----------------------------------------------------------------------------
package ctel_pkg;

    // Table sizes
    localparam int MAX_NODES  = 1024;
    localparam int MAX_EDGES  = 8192;
    localparam int MAX_TYPES  = 8;
    localparam int ROW_DEPTH  = MAX_NODES + 1;
    localparam int TEND_DEPTH = MAX_NODES * MAX_TYPES;

    // Field widths
    localparam int NODE_W  = 10;
    localparam int TYPE_W  = 3;
    localparam int VAL_W   = 14;
    localparam int IDX_W   = 14;
    localparam int POS_W   = 13;
    localparam int KIND_W  = 3;
    localparam int NC_W    = 11;
    localparam int TC_W    = 4;
    localparam int ROW_AW  = $clog2(ROW_DEPTH);
    localparam int TEND_AW = $clog2(TEND_DEPTH);
    localparam int EDGE_AW = $clog2(MAX_EDGES);
    localparam int NODE_AW = $clog2(MAX_NODES);

    // Configuration port
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_COUNT = 1'b1;
    localparam logic [TC_W-1:0]      TYPE_COUNT_RST = 4'd1;

    // Item kinds on the input channel
    localparam logic [KIND_W-1:0] KIND_ROW_WR  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TEND_WR = 3'd1;
    localparam logic [KIND_W-1:0] KIND_NBR_WR  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TYPE_WR = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DIR     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_UND     = 3'd5;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_ROW_WR,
        OP_TEND_WR,
        OP_NBR_WR,
        OP_TYPE_WR,
        OP_DIR,
        OP_UND
    } op_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  write_index;
        logic [VAL_W-1:0]  write_value;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } item_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] edge_position;
        logic             reversed;
    } result_t;

    // One classified command in the queue
    typedef struct packed {
        op_t               op;
        logic [IDX_W-1:0]  index;
        logic [VAL_W-1:0]  value;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic              nodes_ok;
    } cmd_t;

    // Queue status seen by the back end
    typedef struct packed {
        logic valid;
        logic full;
    } q_stat_t;

endpackage

[rtl/ctel_front.sv]
// ----------------------------------------------------------------------------
// ctel_front
// Holds the configuration registers, accepts input beats and classifies
// them into queue commands; drops out-of-range writes and unused kinds.
// ----------------------------------------------------------------------------
module ctel_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [ctel_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ctel_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          start,
    input  ctel_pkg::item_t               item,
    input  ctel_pkg::q_stat_t             q_stat,
    output logic                          busy,
    output logic                          push,
    output ctel_pkg::cmd_t                cmd,
    output logic [ctel_pkg::TC_W-1:0]     type_count
);
    import ctel_pkg::*;

    logic [NC_W-1:0] node_count_reg;
    logic [TC_W-1:0] type_count_reg;
    logic            keep;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= '0;
            type_count_reg <= TYPE_COUNT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_NODE_COUNT: node_count_reg <= cfg_data;
                CFG_TYPE_COUNT: type_count_reg <= cfg_data[TC_W-1:0];
                default: ;
            endcase
        end
    end

    // Classify the beat
    always_comb
    begin
        cmd.index    = item.write_index;
        cmd.value    = item.write_value;
        cmd.node_a   = item.node_a;
        cmd.node_b   = item.node_b;
        cmd.nodes_ok = ({1'b0, item.node_a} < node_count_reg)
                    && ({1'b0, item.node_b} < node_count_reg);
        cmd.op       = OP_DIR;
        keep         = 1'b0;
        unique case (item.kind)
            KIND_ROW_WR:
            begin
                cmd.op = OP_ROW_WR;
                keep   = item.write_index < IDX_W'(ROW_DEPTH);
            end
            KIND_TEND_WR:
            begin
                cmd.op = OP_TEND_WR;
                keep   = item.write_index < IDX_W'(TEND_DEPTH);
            end
            KIND_NBR_WR:
            begin
                cmd.op = OP_NBR_WR;
                keep   = item.write_index < IDX_W'(MAX_EDGES);
            end
            KIND_TYPE_WR:
            begin
                cmd.op = OP_TYPE_WR;
                keep   = item.write_index < IDX_W'(MAX_NODES);
            end
            KIND_DIR:
            begin
                cmd.op = OP_DIR;
                keep   = 1'b1;
            end
            KIND_UND:
            begin
                cmd.op = OP_UND;
                keep   = 1'b1;
            end
            default: keep = 1'b0;
        endcase
    end

    assign busy       = q_stat.full;
    assign push       = start && !q_stat.full && keep;
    assign type_count = type_count_reg;

endmodule

[rtl/ctel_queue.sv]
// ----------------------------------------------------------------------------
// ctel_queue
// Short in-order command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module ctel_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ctel_pkg::cmd_t    push_cmd,
    input  logic              pop,
    output ctel_pkg::cmd_t    head,
    output ctel_pkg::q_stat_t stat
);
    import ctel_pkg::*;

    cmd_t               slot_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               do_push;
    logic               do_pop;

    assign stat.valid = count_reg != '0;
    assign stat.full  = count_reg == Q_CNT_W'(QUEUE_DEPTH);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && stat.valid;
    assign head       = slot_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

[rtl/ctel_back.sv]
// ----------------------------------------------------------------------------
// ctel_back
// Owns the four graph tables, applies table writes and runs the lookup
// sequencer: type read, segment bounds, then a binary search with one
// neighbor read per step; retries b to a for undirected lookups.
// ----------------------------------------------------------------------------
module ctel_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ctel_pkg::cmd_t            head,
    input  ctel_pkg::q_stat_t         q_stat,
    input  logic [ctel_pkg::TC_W-1:0] type_count,
    output logic                      pop,
    output logic                      done,
    output ctel_pkg::result_t         result
);
    import ctel_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TYPE,
        S_BOUND,
        S_END,
        S_START,
        S_CHECK,
        S_PROBE,
        S_CMP
    } state_t;

    // Tables
    logic [VAL_W-1:0]  row_mem  [ROW_DEPTH];
    logic [VAL_W-1:0]  tend_mem [TEND_DEPTH];
    logic [NODE_W-1:0] nbr_mem  [MAX_EDGES];
    logic [TYPE_W-1:0] ntype_mem[MAX_NODES];

    logic [VAL_W-1:0]  rs_rdata_reg;
    logic [VAL_W-1:0]  te_rdata_reg;
    logic [NODE_W-1:0] nb_rdata_reg;
    logic [TYPE_W-1:0] nt_rdata_reg;

    logic row_we, tend_we, nbr_we, ntype_we;
    logic [TEND_AW-1:0] te_raddr;
    logic [EDGE_AW-1:0] mid_w;

    // Sequencer state
    state_t             state_reg;
    logic [NODE_W-1:0]  x_reg;
    logic [NODE_W-1:0]  y_reg;
    logic               und_reg;
    logic               rev_reg;
    logic [TYPE_W-1:0]  t_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [VAL_W-1:0]   base_reg;
    logic [VAL_W:0]     start_reg;
    logic [VAL_W-1:0]   end_reg;
    logic [EDGE_AW-1:0] low_reg;
    logic [EDGE_AW-1:0] high_reg;
    logic [EDGE_AW-1:0] mid_reg;
    logic               res_valid_reg;
    result_t            res_reg;

    logic [IDX_W-1:0] idx_w;
    logic             type_ok;
    logic             idx_ok;
    logic [VAL_W:0]   end_sum;
    logic [VAL_W-1:0] end_clamp;
    logic [VAL_W:0]   start_sum;
    logic             hit;
    logic             miss;

    assign pop = (state_reg == S_IDLE) && q_stat.valid;

    // Write decode of the popped command
    always_comb
    begin
        row_we   = 1'b0;
        tend_we  = 1'b0;
        nbr_we   = 1'b0;
        ntype_we = 1'b0;
        unique case (head.op)
            OP_ROW_WR:  row_we   = pop;
            OP_TEND_WR: tend_we  = pop;
            OP_NBR_WR:  nbr_we   = pop;
            OP_TYPE_WR: ntype_we = pop;
            default: ;
        endcase
    end

    // Table ports: one write, one registered read each
    always_ff @(posedge clk)
    begin
        if (row_we)
            row_mem[head.index[ROW_AW-1:0]] <= head.value;
        rs_rdata_reg <= row_mem[ROW_AW'(x_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (tend_we)
            tend_mem[head.index[TEND_AW-1:0]] <= head.value;
        te_rdata_reg <= tend_mem[te_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (nbr_we)
            nbr_mem[head.index[EDGE_AW-1:0]] <= head.value[NODE_W-1:0];
        nb_rdata_reg <= nbr_mem[mid_w];
    end

    always_ff @(posedge clk)
    begin
        if (ntype_we)
            ntype_mem[head.index[NODE_AW-1:0]] <= head.value[TYPE_W-1:0];
        nt_rdata_reg <= ntype_mem[y_reg];
    end

    // Segment arithmetic and search step
    always_comb
    begin
        idx_w     = ({{(IDX_W-NODE_W){1'b0}}, x_reg} * {{(IDX_W-TC_W){1'b0}}, type_count})
                  + {{(IDX_W-TYPE_W){1'b0}}, nt_rdata_reg};
        type_ok   = {1'b0, nt_rdata_reg} < type_count;
        idx_ok    = idx_w < IDX_W'(TEND_DEPTH);
        end_sum   = {1'b0, rs_rdata_reg} + {1'b0, te_rdata_reg};
        end_clamp = (end_sum > (VAL_W+1)'(MAX_EDGES)) ? VAL_W'(MAX_EDGES)
                                                      : end_sum[VAL_W-1:0];
        start_sum = {1'b0, base_reg} + {1'b0, te_rdata_reg};
        mid_w     = EDGE_AW'(({1'b0, low_reg} + {1'b0, high_reg}) >> 1);
        te_raddr  = (state_reg == S_END) ? TEND_AW'(idx_reg - 1'b1)
                                         : idx_w[TEND_AW-1:0];
        hit       = (state_reg == S_CMP) && (nb_rdata_reg == y_reg);
        miss      = ((state_reg == S_BOUND) && (!type_ok || !idx_ok))
                 || ((state_reg == S_CHECK) && (start_reg >= {1'b0, end_reg}))
                 || ((state_reg == S_CMP) && (nb_rdata_reg > y_reg)
                                          && (mid_reg == low_reg))
                 || ((state_reg == S_CMP) && (nb_rdata_reg < y_reg)
                                          && (mid_reg == high_reg));
    end

    // Lookup sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            rev_reg       <= 1'b0;
            und_reg       <= 1'b0;
        end
        else
        begin
            res_valid_reg <= 1'b0;
            if (hit)
            begin
                res_valid_reg         <= 1'b1;
                res_reg.found         <= 1'b1;
                res_reg.edge_position <= mid_reg;
                res_reg.reversed      <= rev_reg;
                state_reg             <= S_IDLE;
            end
            else if (miss)
            begin
                if (und_reg && !rev_reg)
                begin
                    // retry with the edge turned around
                    x_reg     <= y_reg;
                    y_reg     <= x_reg;
                    rev_reg   <= 1'b1;
                    state_reg <= S_TYPE;
                end
                else
                begin
                    res_valid_reg <= 1'b1;
                    res_reg       <= '0;
                    state_reg     <= S_IDLE;
                end
            end
            else
            begin
                unique case (state_reg)
                    S_IDLE:
                    begin
                        if (pop && (head.op == OP_DIR || head.op == OP_UND))
                        begin
                            x_reg   <= head.node_a;
                            y_reg   <= head.node_b;
                            und_reg <= head.op == OP_UND;
                            rev_reg <= 1'b0;
                            if (head.nodes_ok)
                                state_reg <= S_TYPE;
                            else
                            begin
                                res_valid_reg <= 1'b1;
                                res_reg       <= '0;
                            end
                        end
                    end
                    S_TYPE:
                        state_reg <= S_BOUND;
                    S_BOUND:
                    begin
                        t_reg     <= nt_rdata_reg;
                        idx_reg   <= idx_w;
                        state_reg <= S_END;
                    end
                    S_END:
                    begin
                        base_reg  <= rs_rdata_reg;
                        end_reg   <= end_clamp;
                        start_reg <= {1'b0, rs_rdata_reg};
                        state_reg <= (t_reg == '0) ? S_CHECK : S_START;
                    end
                    S_START:
                    begin
                        start_reg <= start_sum;
                        state_reg <= S_CHECK;
                    end
                    S_CHECK:
                    begin
                        low_reg   <= start_reg[EDGE_AW-1:0];
                        high_reg  <= EDGE_AW'(end_reg - 1'b1);
                        state_reg <= S_PROBE;
                    end
                    S_PROBE:
                    begin
                        mid_reg   <= mid_w;
                        state_reg <= S_CMP;
                    end
                    S_CMP:
                    begin
                        if (nb_rdata_reg > y_reg)
                            high_reg <= mid_reg - 1'b1;
                        else
                            low_reg <= mid_reg + 1'b1;
                        state_reg <= S_PROBE;
                    end
                    default:
                        state_reg <= S_IDLE;
                endcase
            end
        end
    end

    assign done   = res_valid_reg;
    assign result = res_reg;

endmodule

[rtl/csr_typed_edge_lookup.sv]
// ----------------------------------------------------------------------------
// csr_typed_edge_lookup
// Typed CSR graph store with directed and undirected edge lookup.
//
//   channel  | dir | handshake            | beat
//   ---------+-----+----------------------+-------------------------------
//   item     | in  | start high, busy low | kind, index, value, node a/b
//   result   | out | done strobe, 1 cycle | found, edge_position, reversed
//   cfg      | in  | cfg_write            | cfg_index, cfg_data
//
// Table writes take effect in the cycle after they reach the back end. A directed
// lookup reads the node type and the segment bounds, then runs a binary search
// of at most 14 steps for an 8192-entry list, one neighbor read per step on the
// single neighbor table read port; an undirected lookup may run the search twice.
// A 4-entry command queue sits between front and back; busy is queue full.
// Reset clears control state only; tables are undefined until written.
// Results cannot be stalled: result holds each from its done cycle until the next.
// ----------------------------------------------------------------------------
module csr_typed_edge_lookup (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [ctel_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ctel_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           start,
    input  ctel_pkg::item_t                item,
    output logic                           busy,
    output logic                           done,
    output ctel_pkg::result_t              result
);
    import ctel_pkg::*;

    q_stat_t         q_stat;
    cmd_t            push_cmd;
    cmd_t            head;
    logic            push;
    logic            pop;
    logic [TC_W-1:0] type_count;

    // Accept and classify
    ctel_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .start      (start),
        .item       (item),
        .q_stat     (q_stat),
        .busy       (busy),
        .push       (push),
        .cmd        (push_cmd),
        .type_count (type_count)
    );

    // Command queue
    ctel_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    // Tables and lookup engine
    ctel_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_stat     (q_stat),
        .type_count (type_count),
        .pop        (pop),
        .done       (done),
        .result     (result)
    );

endmodule

[rtl/ctel_checker.sv]
// ----------------------------------------------------------------------------
// ctel_checker
// Port-level checks of the edge lookup, bound to the top level.
// ----------------------------------------------------------------------------
module ctel_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input ctel_pkg::result_t result
);
    import ctel_pkg::*;

    // A miss carries no position and no direction
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.found) |-> (result.edge_position == '0 && !result.reversed))
        else $error("miss beat carries position or direction");

    // Only an undirected hit may be marked reversed
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.reversed) |-> result.found)
        else $error("reversed set without a hit");

    // The queue only fills on an accepted beat
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && !busy))
        else $error("busy rose without an accepted beat");

    // Out of reset the block is empty and quiet
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> (!busy && !done))
        else $error("busy or done right after reset");

endmodule

bind csr_typed_edge_lookup ctel_checker u_ctel_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

[tb/sv/csr_typed_edge_lookup_test.sv]
// ----------------------------------------------------------------------------
// csr_typed_edge_lookup_test
// Self-checking bench for the typed CSR edge lookup. Preloads a sparse graph
// on the lowest and highest node blocks (reaching the top of every table),
// runs a short set of directed lookups and writes, then several phases of
// small random typed graphs under varied node and type counts. A local copy
// of the tables predicts each lookup answer when the beat is queued; beats
// keep their order, so the copy matches what the block sees. Lookups that
// would read a table entry never written are not sent.
// ----------------------------------------------------------------------------
module csr_typed_edge_lookup_test;

    import ctel_pkg::*;

    // Kinds with no function in the block
    localparam logic [KIND_W-1:0] KIND_RSVD_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_RSVD_HI = 3'd7;

    localparam int SETTLE_CYCLES = 200;
    localparam int RUN_LIMIT     = 40_000_000;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_BEATS  = 1550;
    localparam int GRAPH_MAX     = 64;
    localparam int PRELOAD_SPAN  = MAX_TYPES;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 start     = 1'b0;
    item_t                item      = '0;
    logic                 busy;
    logic                 done;
    result_t              result;

    // Local copy of the block's tables and registers
    logic [VAL_W-1:0]  row_copy  [ROW_DEPTH];
    logic [VAL_W-1:0]  tend_copy [TEND_DEPTH];
    logic [NODE_W-1:0] nbr_copy  [MAX_EDGES];
    logic [TYPE_W-1:0] type_copy [MAX_NODES];
    int                nodes_in_use = 0;
    int                types_in_use = TYPE_COUNT_RST;

    item_t   pending_beats [$];
    result_t lookup_answers [$];
    int      mismatches   = 0;
    int      random_beats = 0;
    int      gap_left     = 0;
    bit      gaps_on      = 1'b1;

    // Graph of the current phase, kept by the stimulus side
    logic [GRAPH_MAX-1:0] link [GRAPH_MAX];
    int                   node_kind [GRAPH_MAX];

    csr_typed_edge_lookup DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .done      (done),
        .result    (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("FAIL csr_typed_edge_lookup");
        $finish;
    end

    // Binary search of a's neighbors of b's type; returns 1 with pos on a hit.
    // blind is set when the search would read an entry never written.
    function automatic bit search_edge(input int a, input int b, output int pos,
                                       output bit blind);
        int t;
        int base;
        int idx;
        int seg_lo;
        int seg_hi;
        int lo;
        int hi;
        int mid;
        pos   = 0;
        blind = 1'b0;
        if (a >= nodes_in_use || b >= nodes_in_use || a >= MAX_NODES || b >= MAX_NODES)
            return 1'b0;
        if ($isunknown(type_copy[b]) || $isunknown(row_copy[a]))
        begin
            blind = 1'b1;
            return 1'b0;
        end
        t = type_copy[b];
        if (t >= types_in_use)
            return 1'b0;
        base = row_copy[a];
        idx  = a * types_in_use + t;
        if (idx >= TEND_DEPTH)
            return 1'b0;
        if ($isunknown(tend_copy[idx]) || (t != 0 && $isunknown(tend_copy[idx - 1])))
        begin
            blind = 1'b1;
            return 1'b0;
        end
        seg_hi = base + tend_copy[idx];
        seg_lo = (t == 0) ? base : base + tend_copy[idx - 1];
        if (seg_hi > MAX_EDGES)
            seg_hi = MAX_EDGES;
        if (seg_lo >= seg_hi)
            return 1'b0;
        lo = seg_lo;
        hi = seg_hi - 1;
        while (lo <= hi)
        begin
            mid = (lo + hi) / 2;
            if ($isunknown(nbr_copy[mid]))
            begin
                blind = 1'b1;
                return 1'b0;
            end
            if (nbr_copy[mid] == b)
            begin
                pos = mid;
                return 1'b1;
            end
            if (nbr_copy[mid] > b)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        return 1'b0;
    endfunction

    // Update the table copy or queue the answer for one queued beat
    task automatic apply_beat(input item_t it, output bit blind);
        result_t ans;
        bit      hit;
        int      pos;
        ans   = '0;
        blind = 1'b0;
        case (it.kind)
            KIND_ROW_WR:
                if (it.write_index < ROW_DEPTH)
                    row_copy[it.write_index] = it.write_value;
            KIND_TEND_WR:
                if (it.write_index < TEND_DEPTH)
                    tend_copy[it.write_index] = it.write_value;
            KIND_NBR_WR:
                if (it.write_index < MAX_EDGES)
                    nbr_copy[it.write_index] = it.write_value[NODE_W-1:0];
            KIND_TYPE_WR:
                if (it.write_index < MAX_NODES)
                    type_copy[it.write_index] = it.write_value[TYPE_W-1:0];
            KIND_DIR, KIND_UND:
            begin
                hit = search_edge(it.node_a, it.node_b, pos, blind);
                if (!hit && !blind && it.kind == KIND_UND)
                begin
                    hit = search_edge(it.node_b, it.node_a, pos, blind);
                    ans.reversed = hit;
                end
                ans.found         = hit;
                ans.edge_position = hit ? pos[POS_W-1:0] : '0;
                if (!blind)
                    lookup_answers.push_back(ans);
            end
            default: ;
        endcase
    endtask

    // Driver: one beat per accepted start, random gap bursts when enabled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            item     <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    start    <= 1'b0;
                end
                else if (pending_beats.size() != 0)
                begin
                    if (gaps_on && $urandom_range(0, 7) == 0)
                    begin
                        gap_left <= $urandom_range(0, 11);
                        start    <= 1'b0;
                    end
                    else
                    begin
                        start <= 1'b1;
                        item  <= pending_beats.pop_front();
                    end
                end
                else
                    start <= 1'b0;
            end
        end
    end

    task automatic note_mismatch(input string what, input result_t want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t mismatch (%s): expected found=%0d pos=%0d rev=%0d, got found=%0d pos=%0d rev=%0d",
                     $realtime, what, want.found, want.edge_position, want.reversed,
                     result.found, result.edge_position, result.reversed);
    endtask

    // Monitor: every done strobe is one result beat
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (lookup_answers.size() == 0)
                note_mismatch("no lookup pending", '0);
            else if (result.found !== lookup_answers[0].found
                     || result.edge_position !== lookup_answers[0].edge_position
                     || result.reversed !== lookup_answers[0].reversed)
                note_mismatch("field", lookup_answers.pop_front());
            else
                void'(lookup_answers.pop_front());
        end
    end

    // Predict the beat, then hand it to the driver unless it reads unwritten entries
    task automatic queue_beat(input logic [KIND_W-1:0] kind, input int idx, input int val,
                              input int a, input int b);
        item_t it;
        bit    blind;
        it.kind        = kind;
        it.write_index = idx[IDX_W-1:0];
        it.write_value = val[VAL_W-1:0];
        it.node_a      = a[NODE_W-1:0];
        it.node_b      = b[NODE_W-1:0];
        apply_beat(it, blind);
        if (!blind)
        begin
            pending_beats.push_back(it);
            if (kind <= KIND_UND)
                random_beats++;
        end
    endtask

    // Table write with random node fields
    task automatic queue_write(input logic [KIND_W-1:0] kind, input int idx, input int val);
        queue_beat(kind, idx, val, $urandom_range(0, 1023), $urandom_range(0, 1023));
    endtask

    // Lookup with random write fields
    task automatic queue_lookup(input logic [KIND_W-1:0] kind, input int a, input int b);
        queue_beat(kind, $urandom_range(0, 16383), $urandom_range(0, 16383), a, b);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_W-1:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_NODE_COUNT)
            nodes_in_use = val & 32'h7FF;
        else
            types_in_use = val & 32'hF;
    endtask

    // Block idle: all beats taken, all answers back, then let writes retire
    task automatic wait_idle();
        while (pending_beats.size() != 0 || start || lookup_answers.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Preloaded graph: one neighbor per type, from the low or the high node
    // block depending on row parity; node v has type v mod 8
    function automatic int preload_nbr(input int v, input int k);
        return (v % 2 == 1) ? (MAX_NODES - MAX_TYPES + k) : k;
    endfunction

    // Random typed graph over g nodes with the given type stride
    task automatic build_graph(input int g, input int stride, input int base);
        int ptr;
        int row0;
        int v;
        int u;
        int k;
        int tmax;
        tmax = (stride > 8) ? 8 : stride;
        for (u = 0; u < g; u++)
        begin
            node_kind[u] = ($urandom_range(0, 9) == 0) ? 7 : $urandom_range(0, tmax - 1);
            queue_write(KIND_TYPE_WR, u, node_kind[u] | ($urandom_range(0, 2047) << 3));
        end
        ptr = base;
        for (v = 0; v < g; v++)
        begin
            link[v] = '0;
            for (u = 0; u < g; u++)
                link[v][u] = ($urandom_range(0, 2) == 0);
            queue_write(KIND_ROW_WR, v, ptr);
            row0 = ptr;
            // rows sorted by type, then by id
            for (k = 0; k < ((stride > 8) ? stride : 8); k++)
            begin
                for (u = 0; u < g; u++)
                begin
                    if (k < 8 && link[v][u] && node_kind[u] == k)
                    begin
                        queue_write(KIND_NBR_WR, ptr, u);
                        ptr++;
                    end
                end
                if (k < stride)
                    queue_write(KIND_TEND_WR, v * stride + k, ptr - row0);
            end
        end
        queue_write(KIND_ROW_WR, g, ptr);
    endtask

    // Mostly lookups on the phase graph, some far nodes, spare kinds and stray writes
    task automatic queue_phase_lookups(input int g, input int count);
        int               n;
        int               r;
        int               a;
        int               b;
        int               u;
        int               off;
        int               j;
        bit               got;
        logic [KIND_W-1:0] kind;
        for (n = 0; n < count; n++)
        begin
            r    = $urandom_range(0, 99);
            kind = $urandom_range(0, 1) ? KIND_DIR : KIND_UND;
            a    = $urandom_range(0, g - 1);
            b    = $urandom_range(0, g - 1);
            if (r < 45)
            begin
                got = 1'b0;
                off = $urandom_range(0, g - 1);
                for (j = 0; j < g; j++)
                begin
                    u = (off + j) % g;
                    if (!got && link[a][u])
                    begin
                        b   = u;
                        got = 1'b1;
                    end
                end
                if (kind == KIND_UND && $urandom_range(0, 1))
                    queue_lookup(kind, b, a);
                else
                    queue_lookup(kind, a, b);
            end
            else if (r < 75)
                queue_lookup(kind, a, b);
            else if (r < 85)
                queue_lookup(kind, $urandom_range(0, 1023), $urandom_range(0, 1023));
            else if (r < 90)
                queue_lookup(kind, a, a);
            else if (r < 94)
                queue_beat($urandom_range(0, 1) ? KIND_RSVD_LO : KIND_RSVD_HI,
                           $urandom_range(0, 16383), $urandom_range(0, 16383),
                           $urandom_range(0, 1023), $urandom_range(0, 1023));
            else
            begin
                case ($urandom_range(0, 3))
                    0:       kind = KIND_ROW_WR;
                    1:       kind = KIND_TEND_WR;
                    2:       kind = KIND_NBR_WR;
                    default: kind = KIND_TYPE_WR;
                endcase
                queue_write(kind,
                            $urandom_range(0, 1) ? $urandom_range(0, 16383)
                                                 : $urandom_range(0, 4 * g),
                            $urandom_range(0, 1) ? $urandom_range(0, 16383)
                                                 : $urandom_range(0, 20));
            end
        end
    endtask

    // Stimulus sequence
    initial
    begin
        int phase;
        int g;
        int stride;
        int nodes;
        int base;
        int count;
        int v;
        int k;
        int j;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset registers: no node is in use, nothing is read
        queue_lookup(KIND_DIR, 0, 0);
        queue_lookup(KIND_UND, 1023, 1023);
        wait_idle();

        write_reg(CFG_NODE_COUNT, MAX_NODES);
        write_reg(CFG_TYPE_COUNT, MAX_TYPES);

        // Preload the lowest and highest node blocks, up to the last entry of each table
        gaps_on = 1'b0;
        for (j = 0; j < 2 * PRELOAD_SPAN; j++)
        begin
            v = (j < PRELOAD_SPAN) ? j : MAX_NODES - 2 * PRELOAD_SPAN + j;
            queue_write(KIND_TYPE_WR, v, v % MAX_TYPES);
            queue_write(KIND_ROW_WR, v, v * MAX_TYPES);
            for (k = 0; k < MAX_TYPES; k++)
            begin
                queue_write(KIND_TEND_WR, v * MAX_TYPES + k, k + 1);
                queue_write(KIND_NBR_WR, v * MAX_TYPES + k, preload_nbr(v, k));
            end
        end
        queue_write(KIND_ROW_WR, MAX_NODES, MAX_NODES * MAX_TYPES);
        gaps_on = 1'b1;

        // Directed: first and last edge, both directions, spare kinds
        queue_lookup(KIND_DIR, 0, preload_nbr(0, 0));
        queue_lookup(KIND_DIR, 1023, preload_nbr(1023, 7));
        queue_lookup(KIND_DIR, 1023, 5);
        queue_lookup(KIND_UND, preload_nbr(5, 3), 5);
        queue_lookup(KIND_UND, 5, preload_nbr(5, 3));
        queue_beat(KIND_RSVD_LO, 0, 0, 0, 0);
        queue_beat(KIND_RSVD_HI, 16383, 16383, 1023, 1023);
        // writes past each table end are dropped
        queue_write(KIND_ROW_WR, ROW_DEPTH, 16383);
        queue_write(KIND_TEND_WR, TEND_DEPTH, 16383);
        queue_write(KIND_NBR_WR, 16383, 16383);
        queue_write(KIND_TYPE_WR, MAX_NODES, 16383);
        // value masked to the table width
        queue_write(KIND_TYPE_WR, 1000, 16383);
        queue_lookup(KIND_DIR, 3, 1000);
        queue_write(KIND_NBR_WR, 6 * MAX_TYPES + 4, 16383);
        queue_write(KIND_TYPE_WR, 1023, 4);
        queue_lookup(KIND_DIR, 6, 1023);
        // segment running past the list end is clamped
        queue_write(KIND_TEND_WR, 1023 * MAX_TYPES, 30);
        queue_lookup(KIND_DIR, 1023, 0);
        queue_lookup(KIND_DIR, 1023, 1016);
        // inverted and empty segments
        queue_write(KIND_TEND_WR, 2 * MAX_TYPES + 4, 0);
        queue_lookup(KIND_DIR, 2, preload_nbr(2, 4));
        queue_write(KIND_TEND_WR, 3 * MAX_TYPES + 2, 2);
        queue_lookup(KIND_UND, 3, preload_nbr(3, 2));

        // Random phases, each with its own register setting and graph
        random_beats = 0;
        for (phase = 0; phase < 7 || random_beats < RANDOM_BEATS; phase++)
        begin
            wait_idle();
            gaps_on = (random_beats < RANDOM_BEATS - 400);
            g       = (phase == 1) ? 24 : $urandom_range(2, 16);
            case (phase)
                0:       begin nodes = g;         stride = $urandom_range(1, 8); end
                1:       begin nodes = MAX_NODES; stride = MAX_TYPES;            end
                2:       begin nodes = g / 2;     stride = $urandom_range(1, 4); end
                3:       begin nodes = 2047;      stride = 1;                    end
                4:       begin nodes = $urandom_range(0, 1024); stride = 0;      end
                5:       begin nodes = MAX_NODES; stride = 15;                   end
                6:       begin nodes = 0;         stride = $urandom_range(1, 8); end
                default: begin nodes = $urandom_range(g, 1024); stride = $urandom_range(1, 8); end
            endcase
            write_reg(CFG_NODE_COUNT, nodes);
            write_reg(CFG_TYPE_COUNT, stride);
            case ($urandom_range(0, 3))
                0:       base = 0;
                3:       base = MAX_EDGES - $urandom_range(0, 20);
                default: base = $urandom_range(0, 7000);
            endcase
            if (stride != 0)
                build_graph(g, stride, base);
            count = (stride == 0 || nodes == 0) ? 25 : $urandom_range(60, 120);
            queue_phase_lookups(g, count);
        end

        gaps_on = 1'b0;
        wait_idle();
        if (mismatches == 0)
            $display("PASS csr_typed_edge_lookup");
        else
            $display("FAIL csr_typed_edge_lookup");
        $finish;
    end

endmodule
